// ===== sv/nstm_pkg.sv =====
package nstm_pkg;

  // Default number of slots in the table.
  localparam int unsigned SLOTS_DEF = 8;

  // Width of a stored sequence number.
  localparam int unsigned NUM_W = 32;

  // Width of a slot index as it travels in a result word.
  localparam int unsigned IDX_OUT_W = 3;

  localparam int unsigned OP_W = 2;

  // Stream word widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  // Operation codes; the unused code behaves as a report.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

endpackage

// ===== sv/nstm_ram.sv =====
module nstm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/nstm_scan.sv =====
module nstm_scan #(
  parameter int unsigned SLOTS = nstm_pkg::SLOTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         en_i,
  input  logic [$clog2(SLOTS)-1:0]     idx_i,
  input  logic [nstm_pkg::NUM_W-1:0]   val_i,
  input  logic [nstm_pkg::NUM_W-1:0]   key_i,
  output logic [nstm_pkg::NUM_W-1:0]   max_num_o,
  output logic [$clog2(SLOTS)-1:0]     max_idx_o,
  output logic [nstm_pkg::NUM_W-1:0]   sec_num_o,
  output logic [$clog2(SLOTS)-1:0]     sec_idx_o,
  output logic [$clog2(SLOTS)-1:0]     min_idx_o,
  output logic                         hit_o,
  output logic [$clog2(SLOTS)-1:0]     hit_idx_o
);

  localparam int unsigned IW = $clog2(SLOTS);

  logic [nstm_pkg::NUM_W-1:0] max_num_q, max_num_d;
  logic [nstm_pkg::NUM_W-1:0] sec_num_q, sec_num_d;
  logic [nstm_pkg::NUM_W-1:0] min_num_q, min_num_d;
  logic [IW-1:0]              max_idx_q, max_idx_d;
  logic [IW-1:0]              sec_idx_q, sec_idx_d;
  logic [IW-1:0]              min_idx_q, min_idx_d;
  logic [IW-1:0]              hit_idx_q, hit_idx_d;
  logic                       hit_q, hit_d;

  // Largest and second largest are tracked together: a new maximum pushes
  // the old one down, which keeps the first slot of each value.
  always_comb begin
    max_num_d = max_num_q;
    max_idx_d = max_idx_q;
    sec_num_d = sec_num_q;
    sec_idx_d = sec_idx_q;
    min_num_d = min_num_q;
    min_idx_d = min_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    if (clr_i) begin
      max_num_d = '0;
      max_idx_d = '0;
      sec_num_d = '0;
      sec_idx_d = '0;
      min_num_d = '1;
      min_idx_d = '0;
      hit_d     = 1'b0;
      hit_idx_d = '0;
    end else if (en_i) begin
      if (val_i > max_num_q) begin
        sec_num_d = max_num_q;
        sec_idx_d = max_idx_q;
        max_num_d = val_i;
        max_idx_d = idx_i;
      end else if (val_i < max_num_q && val_i > sec_num_q) begin
        sec_num_d = val_i;
        sec_idx_d = idx_i;
      end
      if (val_i < min_num_q) begin
        min_num_d = val_i;
        min_idx_d = idx_i;
      end
      if (!hit_q && val_i == key_i) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_num_q <= max_num_d;
    max_idx_q <= max_idx_d;
    sec_num_q <= sec_num_d;
    sec_idx_q <= sec_idx_d;
    min_num_q <= min_num_d;
    min_idx_q <= min_idx_d;
    hit_idx_q <= hit_idx_d;
  end

  assign max_num_o = max_num_q;
  assign max_idx_o = max_idx_q;
  assign sec_num_o = sec_num_q;
  assign sec_idx_o = sec_idx_q;
  assign min_idx_o = min_idx_q;
  assign hit_o     = hit_q;
  assign hit_idx_o = hit_idx_q;

endmodule

// ===== sv/numbered_slot_table_manager.sv =====
// Numbered slot table: SLOTS slots in a small RAM, each holding a 32-bit
// sequence number, where zero marks an empty slot.
// Commands arrive as words on the s_axis channel: an add puts the largest
// stored number plus one into the first slot holding the smallest number,
// a remove clears the first slot holding the given number, and a report
// changes nothing. Each command yields exactly one word on m_axis that
// describes the table after the command: the slot touched, a success flag,
// the number assigned, the newest and second newest slots and the oldest.
// Each command makes two passes over the single RAM read port, one before
// the write and one after it, at one slot per cycle. The result and ready
// return together, in the same cycle.
// Commands are handled one at a time. A finished result sits in an output
// register, so a new command is taken while it waits; if the receiver
// still stalls when the next result is ready, the block holds that result
// internally until the output register is free.
// Reset empties the table at once through per-slot valid bits, so the
// block is ready in the first cycle after reset.
module numbered_slot_table_manager #(
  parameter int unsigned SLOTS = nstm_pkg::SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata from bit 0: op[1:0], number[33:2], zero padding[39:34]
  input  logic [nstm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata from bit 0: slot_index[2:0], op_ok[3], assigned_number[35:4],
  // last_slot[38:36], last_found[39], second_slot[42:40],
  // second_found[43], oldest_slot[46:44], zero padding[47]
  output logic [nstm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned NUM_W = nstm_pkg::NUM_W;
  localparam int unsigned XW    = nstm_pkg::IDX_OUT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN1 = 5'b00010,
    ST_WRITE = 5'b00100,
    ST_SCAN2 = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [nstm_pkg::OP_W-1:0] op_q;
  logic [NUM_W-1:0]          key_q;
  logic [CW-1:0]             rd_cnt_q, rd_cnt_d;
  logic                      rv_q;
  logic [IW-1:0]             ri_q;
  logic                      rvld_q;
  logic [SLOTS-1:0]          vld_q;

  logic                      in_scan;
  logic                      issue;
  logic                      scan_last;
  logic                      scan_clr;
  logic [IW-1:0]             rd_addr;
  logic [NUM_W-1:0]          rd_data;
  logic [NUM_W-1:0]          slot_val;

  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic [NUM_W-1:0]          wr_data;

  logic [NUM_W-1:0]          max_num;
  logic [IW-1:0]             max_idx;
  logic [NUM_W-1:0]          sec_num;
  logic [IW-1:0]             sec_idx;
  logic [IW-1:0]             min_idx;
  logic                      hit;
  logic [IW-1:0]             hit_idx;

  logic [XW-1:0]             res_slot_q, res_slot_d;
  logic                      res_ok_q, res_ok_d;
  logic [NUM_W-1:0]          res_num_q, res_num_d;

  logic                      out_vld_q;
  logic [nstm_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                      out_load;

  logic                      in_acc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign in_scan   = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);
  assign issue     = in_scan && (rd_cnt_q < CW'(SLOTS));
  assign rd_addr   = rd_cnt_q[IW-1:0];
  assign scan_last = rv_q && (ri_q == IW'(SLOTS - 1));
  assign scan_clr  = in_acc || (state_q == ST_WRITE);

  // A slot never written since reset reads as empty.
  assign slot_val = rvld_q ? rd_data : '0;

  assign out_load = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  nstm_ram #(
    .WIDTH (NUM_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nstm_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (scan_clr),
    .en_i      (rv_q),
    .idx_i     (ri_q),
    .val_i     (slot_val),
    .key_i     (key_q),
    .max_num_o (max_num),
    .max_idx_o (max_idx),
    .sec_num_o (sec_num),
    .sec_idx_o (sec_idx),
    .min_idx_o (min_idx),
    .hit_o     (hit),
    .hit_idx_o (hit_idx)
  );

  // The write uses the figures of the first pass; the second pass then
  // sees the updated table.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = min_idx;
    wr_data    = max_num + NUM_W'(1);
    res_slot_d = res_slot_q;
    res_ok_d   = res_ok_q;
    res_num_d  = res_num_q;
    if (state_q == ST_WRITE) begin
      res_slot_d = '0;
      res_ok_d   = 1'b0;
      res_num_d  = '0;
      case (op_q)
        nstm_pkg::OP_ADD: begin
          wr_en      = 1'b1;
          res_slot_d = XW'(min_idx);
          res_ok_d   = 1'b1;
          res_num_d  = wr_data;
        end
        nstm_pkg::OP_REMOVE: begin
          wr_addr = hit_idx;
          wr_data = '0;
          if (hit) begin
            wr_en      = 1'b1;
            res_slot_d = XW'(hit_idx);
            res_ok_d   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    if (issue) begin
      rd_cnt_d = rd_cnt_q + CW'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        rd_cnt_d = '0;
        if (in_acc) begin
          state_d = ST_SCAN1;
        end
      end
      ST_SCAN1: begin
        if (scan_last) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        rd_cnt_d = '0;
        state_d  = ST_SCAN2;
      end
      ST_SCAN2: begin
        if (scan_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      rv_q      <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      rv_q     <= issue;
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tdata[nstm_pkg::OP_W-1:0];
      key_q <= s_axis_tdata[nstm_pkg::OP_W +: NUM_W];
    end
    ri_q       <= rd_addr;
    rvld_q     <= vld_q[rd_addr];
    res_slot_q <= res_slot_d;
    res_ok_q   <= res_ok_d;
    res_num_q  <= res_num_d;
    if (out_load) begin
      out_data_q <= {1'b0,
                     XW'(min_idx),
                     (sec_num != '0),
                     XW'(sec_idx),
                     (max_num != '0),
                     XW'(max_idx),
                     res_num_q,
                     res_ok_q,
                     res_slot_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_scan_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rv_q)
    else $error("read pipeline busy while idle");

  a_write_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_WRITE) && !rv_q)
    else $error("table written outside the write step");

  a_first_pass_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN1) && scan_last |=> (state_q == ST_WRITE))
    else $error("first pass did not lead to the write step");

  a_second_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (state_q == ST_SCAN2) && (rd_cnt_q == '0))
    else $error("second pass did not start from slot zero");

  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the done step");

endmodule
